### sv/cpte_pkg.sv
`default_nettype none
package cpte_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] proc_id;
    logic [47:0] start_vaddr;
    logic [6:0]  page_count;
    logic [7:0]  home_block;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] page_index;
    logic       placed_table;
    logic [7:0] placed_block;
    logic       last_page;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] owner;
    logic [47:0] addr;
  } slot_t;

  localparam logic       KIND_INSERT = 1'b0;
  localparam logic       KIND_REMOVE = 1'b1;

  localparam logic [2:0] STAT_PLACED    = 3'd0;
  localparam logic [2:0] STAT_PRESENT   = 3'd1;
  localparam logic [2:0] STAT_FAILED    = 3'd2;
  localparam logic [2:0] STAT_REMOVED   = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  localparam logic [1:0] REG_PAGE_SHIFT = 2'd0;
  localparam logic [1:0] REG_MAX_INS    = 2'd1;
  localparam logic [1:0] REG_MAX_REM    = 2'd2;

  localparam logic [4:0]  PAGE_SHIFT_RST = 5'd12;
  localparam logic [4:0]  PAGE_SHIFT_MIN = 5'd9;
  localparam logic [4:0]  PAGE_SHIFT_MAX = 5'd16;
  localparam logic [12:0] MAX_INS_RST    = 13'd512;
  localparam logic [12:0] MAX_REM_RST    = 13'd256;
  localparam logic [6:0]  MAX_PAGES      = 7'd64;

endpackage
`default_nettype wire

### sv/cpte_ram.sv
`default_nettype none
module cpte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/cuckoo_page_table_engine_unit.sv
// Per page: a setup state, a bytewise offset remainder for non-power-of-two PAGES_PER_BLOCK,
// then a read and an evaluate state per displacement or probe step; results registered.
// Throughput: one request at a time; busy drops as the last page result is driven.
// Step count is set by the read-modify-write loop on the single slot-row memory.
// Reset: a clearing pass writes every row, busy held high.
// Results are one-cycle strobes; the receiver cannot stall.
`default_nettype none
module cuckoo_page_table_engine_unit #(
  parameter int TABLES          = 2,
  parameter int BLOCKS          = 256,
  parameter int PAGES_PER_BLOCK = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire cpte_pkg::req_t req_i,
  output logic                res_valid_o,
  output cpte_pkg::rsp_t      res_o,
  input  wire logic           psel,
  input  wire logic           penable,
  input  wire logic           pwrite,
  input  wire logic [3:0]     paddr,
  input  wire logic [31:0]    pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import cpte_pkg::*;

  localparam int Depth = BLOCKS * PAGES_PER_BLOCK;
  localparam int AW    = $clog2(Depth);
  localparam int BW    = $clog2(BLOCKS);
  localparam int OW    = (PAGES_PER_BLOCK > 1) ? $clog2(PAGES_PER_BLOCK) : 1;
  localparam int TW    = $clog2(TABLES);
  localparam int SW    = $bits(slot_t);
  localparam bit IsPow2 = (PAGES_PER_BLOCK & (PAGES_PER_BLOCK - 1)) == 0;
  localparam longint RecipPage = (longint'(1) << 32) / PAGES_PER_BLOCK;
  localparam longint RecipBlk  = (longint'(1) << 32) / BLOCKS;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_PAGE = 3'd2;
  localparam logic [2:0] S_MOD  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EV   = 3'd5;

  function automatic logic [15:0] rem_const(input logic [15:0] x, input logic [32:0] recip,
                                            input logic [16:0] d);
    logic [48:0] prod;
    logic [32:0] r;
    prod = 49'(x) * 49'(recip);
    r = 33'(x) - 33'(prod[47:32]) * 33'(d);
    if (r >= 33'(d)) begin
      r = r - 33'(d);
    end
    return r[15:0];
  endfunction

  function automatic logic [BW-1:0] mod_blocks(input logic [7:0] h);
    return BW'(rem_const({8'd0, h}, 33'(RecipBlk), 17'(BLOCKS)));
  endfunction

  function automatic logic [AW-1:0] row_of(input logic [BW-1:0] b, input logic [OW-1:0] o);
    return AW'(int'(b) * PAGES_PER_BLOCK + int'(o));
  endfunction

  logic [2:0]  state_q, state_d;
  logic [4:0]  pshift_q;
  logic [12:0] max_ins_q, max_rem_q;
  logic [AW-1:0] clr_q, clr_d;
  logic        kind_q, kind_d;
  logic [15:0] proc_q, proc_d, cown_q, cown_d;
  logic [47:0] addr_q, addr_d, caddr_q, caddr_d, sh_q, sh_d;
  logic [6:0]  left_q, left_d;
  logic [5:0]  idx_q, idx_d, mcnt_q, mcnt_d;
  logic [BW-1:0] home_q, home_d, b_q, b_d;
  logic [TW-1:0] t_q, t_d;
  logic [12:0] tries_q, tries_d;
  logic [OW-1:0] off_q, off_d;
  logic [7:0]  rem_q, rem_d, rem_n;
  logic        res_valid_d;
  rsp_t        res_d;

  logic [4:0]  shift;
  logic [47:0] shifted;
  logic [6:0]  cnt;
  logic        we, re;
  logic [AW-1:0] waddr;
  slot_t [TABLES-1:0] row, wrow;
  logic [SW*TABLES-1:0] rdata;
  logic [TABLES-1:0] match;
  logic        hit;
  logic [TW-1:0] hit_t;
  logic        emit;
  logic [2:0]  e_stat;
  logic [TW-1:0] e_t;
  logic [BW-1:0] e_b;

  assign pready = 1'b1;
  assign busy   = (state_q != S_IDLE);

  always_comb begin
    shift = pshift_q;
    if (shift < PAGE_SHIFT_MIN) shift = PAGE_SHIFT_MIN;
    if (shift > PAGE_SHIFT_MAX) shift = PAGE_SHIFT_MAX;
  end

  assign shifted = addr_q >> shift;
  assign cnt     = (req_i.page_count > MAX_PAGES) ? MAX_PAGES : req_i.page_count;
  assign rem_n   = 8'(rem_const({rem_q, sh_q[47:40]}, 33'(RecipPage), 17'(PAGES_PER_BLOCK)));
  assign row     = rdata;

  always_comb begin
    match = '0;
    hit   = 1'b0;
    hit_t = '0;
    for (int i = 0; i < TABLES; i++) begin
      match[i] = row[i].valid && row[i].owner == cown_q && row[i].addr == caddr_q;
    end
    for (int i = TABLES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit   = 1'b1;
        hit_t = TW'(i);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    kind_d = kind_q;
    proc_d = proc_q;
    cown_d = cown_q;
    addr_d = addr_q;
    caddr_d = caddr_q;
    sh_d = sh_q;
    left_d = left_q;
    idx_d = idx_q;
    mcnt_d = mcnt_q;
    home_d = home_q;
    b_d = b_q;
    t_d = t_q;
    tries_d = tries_q;
    off_d = off_q;
    rem_d = rem_q;
    we = 1'b0;
    re = 1'b0;
    waddr = row_of(b_q, off_q);
    wrow = row;
    emit = 1'b0;
    e_stat = STAT_PLACED;
    e_t = '0;
    e_b = '0;
    unique case (state_q)
      S_CLR: begin
        we = 1'b1;
        waddr = clr_q;
        wrow = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Depth - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          kind_d = req_i.kind;
          proc_d = req_i.proc_id;
          addr_d = req_i.start_vaddr;
          left_d = cnt;
          idx_d = '0;
          home_d = mod_blocks(req_i.home_block);
          if (cnt != '0) state_d = S_PAGE;
        end
      end
      S_PAGE: begin
        cown_d = proc_q;
        caddr_d = addr_q;
        t_d = '0;
        b_d = home_q;
        tries_d = '0;
        if (IsPow2) begin
          off_d = OW'(shifted & 48'(PAGES_PER_BLOCK - 1));
          state_d = S_RD;
        end else begin
          sh_d = shifted;
          rem_d = '0;
          mcnt_d = '0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        rem_d = rem_n;
        sh_d = {sh_q[39:0], 8'd0};
        mcnt_d = mcnt_q + 1'b1;
        if (mcnt_q == 6'd5) begin
          off_d = OW'(rem_n);
          state_d = S_RD;
        end
      end
      S_RD: begin
        re = 1'b1;
        state_d = S_EV;
      end
      S_EV: begin
        state_d = S_RD;
        if (kind_q == KIND_INSERT) begin
          if (tries_q == max_ins_q) begin
            emit = 1'b1;
            e_stat = STAT_FAILED;
          end else if (hit) begin
            emit = 1'b1;
            e_stat = (tries_q == '0) ? STAT_PRESENT : STAT_PLACED;
            e_t = hit_t;
            e_b = b_q;
          end else if (row[t_q].valid) begin
            we = 1'b1;
            wrow[t_q] = '{valid: 1'b1, owner: cown_q, addr: caddr_q};
            cown_d = row[t_q].owner;
            caddr_d = row[t_q].addr;
            tries_d = tries_q + 1'b1;
            if (t_q == TW'(TABLES - 1)) begin
              t_d = '0;
              b_d = (b_q == BW'(BLOCKS - 1)) ? '0 : b_q + 1'b1;
            end else begin
              t_d = t_q + 1'b1;
            end
          end else begin
            we = 1'b1;
            wrow[t_q] = '{valid: 1'b1, owner: cown_q, addr: caddr_q};
            emit = 1'b1;
            e_stat = STAT_PLACED;
            e_t = t_q;
            e_b = b_q;
          end
        end else begin
          if (tries_q == max_rem_q) begin
            emit = 1'b1;
            e_stat = STAT_NOT_FOUND;
          end else if (hit) begin
            we = 1'b1;
            wrow[hit_t].valid = 1'b0;
            emit = 1'b1;
            e_stat = STAT_REMOVED;
            e_t = hit_t;
            e_b = b_q;
          end else begin
            tries_d = tries_q + 1'b1;
            b_d = (b_q == BW'(BLOCKS - 1)) ? '0 : b_q + 1'b1;
          end
        end
        if (emit) begin
          left_d = left_q - 1'b1;
          idx_d = idx_q + 1'b1;
          addr_d = addr_q + (48'd1 << shift);
          state_d = (left_q == 7'd1) ? S_IDLE : S_PAGE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res_valid_d = emit;
    res_d.status = e_stat;
    res_d.page_index = idx_q;
    res_d.placed_table = e_t[0];
    res_d.placed_block = 8'(e_b);
    res_d.last_page = (left_q == 7'd1);
  end

  cpte_ram #(
    .Width(SW * TABLES),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wrow),
    .re_i   (re),
    .raddr_i(row_of(b_q, off_q)),
    .rdata_o(rdata)
  );

  always_comb begin
    unique case (paddr[3:2])
      REG_PAGE_SHIFT: prdata = 32'(pshift_q);
      REG_MAX_INS:    prdata = 32'(max_ins_q);
      REG_MAX_REM:    prdata = 32'(max_rem_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pshift_q <= PAGE_SHIFT_RST;
      max_ins_q <= MAX_INS_RST;
      max_rem_q <= MAX_REM_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PAGE_SHIFT: pshift_q <= pwdata[4:0];
        REG_MAX_INS:    max_ins_q <= pwdata[12:0];
        REG_MAX_REM:    max_rem_q <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      res_valid_o <= 1'b0;
      left_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      res_valid_o <= res_valid_d;
      left_q <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    proc_q <= proc_d;
    cown_q <= cown_d;
    addr_q <= addr_d;
    caddr_q <= caddr_d;
    sh_q <= sh_d;
    idx_q <= idx_d;
    mcnt_q <= mcnt_d;
    home_q <= home_d;
    b_q <= b_d;
    t_q <= t_d;
    tries_q <= tries_d;
    off_q <= off_d;
    rem_q <= rem_d;
    res_o <= res_d;
  end

  a_res_from_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(state_q) == S_EV)
    else $error("result strobe without an evaluate cycle");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == S_CLR || state_q == S_EV))
    else $error("slot write outside clear or evaluate");

  a_eval_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EV |-> $past(state_q) == S_RD)
    else $error("evaluate without a read beat");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.status <= STAT_NOT_FOUND)
    else $error("status code out of range");

  a_table_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EV |-> int'(t_q) < TABLES)
    else $error("table index out of range");

endmodule
`default_nettype wire

### dv/cuckoo_page_table_engine_unit_tb.sv
`timescale 1ns / 1ps
module cuckoo_page_table_engine_unit_tb;
  import cpte_pkg::*;

  localparam int NTAB  = 2;
  localparam int NBLK  = 256;
  localparam int NPAGE = 16;
  localparam int NSLOT = NTAB * NBLK * NPAGE;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        res_valid_o;
  rsp_t        res_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cuckoo_page_table_engine_unit i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .res_valid_o(res_valid_o), .res_o(res_o), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // table shadow and register copies
  logic        tbl_valid [NSLOT];
  logic [15:0] tbl_owner [NSLOT];
  logic [47:0] tbl_addr  [NSLOT];
  logic [4:0]  cfg_shift;
  logic [12:0] cfg_ins_tries;
  logic [12:0] cfg_rem_tries;

  req_t pend_q[$];
  rsp_t page_rsp_q[$];
  req_t inserted_q[$];
  int   err_cnt;
  int   idle_pct;
  logic nxt_start;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int slot_idx(int t, int b, int off);
    return (t * NBLK + b) * NPAGE + off;
  endfunction

  task automatic place_page(input logic [15:0] own_in, input logic [47:0] addr_in,
                            input int home, input int off, output rsp_t r);
    logic [15:0] own;
    logic [47:0] addr;
    logic [15:0] o2;
    logic [47:0] a2;
    int t;
    int b;
    int steps;
    int s;
    r = '0;
    own = own_in;
    addr = addr_in;
    t = 0;
    b = home;
    steps = 0;
    forever begin
      if (steps == cfg_ins_tries) begin
        r.status = STAT_FAILED;
        return;
      end
      for (int i = 0; i < NTAB; i++) begin
        s = slot_idx(i, b, off);
        if (tbl_valid[s] && tbl_owner[s] == own && tbl_addr[s] == addr) begin
          r.status = (steps == 0) ? STAT_PRESENT : STAT_PLACED;
          r.placed_table = i[0];
          r.placed_block = b[7:0];
          return;
        end
      end
      s = slot_idx(t, b, off);
      if (tbl_valid[s]) begin
        o2 = tbl_owner[s];
        a2 = tbl_addr[s];
        tbl_owner[s] = own;
        tbl_addr[s] = addr;
        own = o2;
        addr = a2;
        if (t == NTAB - 1) begin
          t = 0;
          b = (b + 1) % NBLK;
        end else begin
          t++;
        end
        steps++;
      end else begin
        tbl_valid[s] = 1'b1;
        tbl_owner[s] = own;
        tbl_addr[s] = addr;
        r.status = STAT_PLACED;
        r.placed_table = t[0];
        r.placed_block = b[7:0];
        return;
      end
    end
  endtask

  task automatic clear_page(input logic [15:0] own, input logic [47:0] addr,
                            input int home, input int off, output rsp_t r);
    int b;
    int s;
    r = '0;
    b = home;
    for (int n = 0; n != cfg_rem_tries; n++) begin
      for (int i = 0; i < NTAB; i++) begin
        s = slot_idx(i, b, off);
        if (tbl_valid[s] && tbl_owner[s] == own && tbl_addr[s] == addr) begin
          tbl_valid[s] = 1'b0;
          r.status = STAT_REMOVED;
          r.placed_table = i[0];
          r.placed_block = b[7:0];
          return;
        end
      end
      b = (b + 1) % NBLK;
    end
    r.status = STAT_NOT_FOUND;
  endtask

  task automatic predict_pages(input req_t q);
    int shift;
    int cnt;
    logic [47:0] addr;
    int off;
    rsp_t r;
    shift = cfg_shift;
    if (shift < PAGE_SHIFT_MIN) shift = PAGE_SHIFT_MIN;
    if (shift > PAGE_SHIFT_MAX) shift = PAGE_SHIFT_MAX;
    cnt = q.page_count;
    if (cnt > MAX_PAGES) cnt = MAX_PAGES;
    for (int i = 0; i < cnt; i++) begin
      addr = q.start_vaddr + (48'(i) << shift);
      off = (addr >> shift) % NPAGE;
      r = '0;
      if (q.kind == KIND_INSERT) place_page(q.proc_id, addr, q.home_block % NBLK, off, r);
      else clear_page(q.proc_id, addr, q.home_block % NBLK, off, r);
      r.page_index = i[5:0];
      r.last_page = (i + 1 == cnt);
      page_rsp_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      nxt_start = start;
      if (start && !busy) begin
        predict_pages(req_i);
        if (req_i.kind == KIND_INSERT) inserted_q.push_back(req_i);
        void'(pend_q.pop_front());
        nxt_start = 1'b0;
      end
      if (!nxt_start && pend_q.size() > 0 && $urandom_range(99) >= idle_pct)
        nxt_start = 1'b1;
      start <= nxt_start;
      if (nxt_start) req_i <= pend_q[0];
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (page_rsp_q.size() == 0) begin
        report_mismatch("page result with none expected");
      end else begin
        if (res_o !== page_rsp_q[0])
          report_mismatch($sformatf("got st=%0d idx=%0d t=%0d b=%0d last=%0d, exp %0d %0d %0d %0d %0d",
            res_o.status, res_o.page_index, res_o.placed_table, res_o.placed_block,
            res_o.last_page, page_rsp_q[0].status, page_rsp_q[0].page_index,
            page_rsp_q[0].placed_table, page_rsp_q[0].placed_block, page_rsp_q[0].last_page));
        void'(page_rsp_q.pop_front());
      end
    end
  end

  task automatic wait_idle();
    while (pend_q.size() > 0 || page_rsp_q.size() > 0 || start || busy) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PAGE_SHIFT: cfg_shift = val[4:0];
      REG_MAX_INS:    cfg_ins_tries = val[12:0];
      REG_MAX_REM:    cfg_rem_tries = val[12:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [31:0] sh, input logic [31:0] ins, input logic [31:0] rem);
    wait_idle();
    write_reg(REG_PAGE_SHIFT, sh);
    write_reg(REG_MAX_INS, ins);
    write_reg(REG_MAX_REM, rem);
  endtask

  function automatic req_t mk_req(logic k, logic [15:0] p, logic [47:0] a,
                                  logic [6:0] c, logic [7:0] h);
    req_t q;
    q.kind = k;
    q.proc_id = p;
    q.start_vaddr = a;
    q.page_count = c;
    q.home_block = h;
    return q;
  endfunction

  // part reinsert/remove of earlier beats, part new beats, new ones mostly on crowded home blocks
  function automatic req_t rand_req(int max_cnt);
    req_t q;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45 && inserted_q.size() > 0) begin
      q = inserted_q[$urandom_range(inserted_q.size() - 1)];
      q.kind = ($urandom_range(3) == 0) ? KIND_INSERT : KIND_REMOVE;
    end else begin
      q.kind = (pick < 92) ? KIND_INSERT : KIND_REMOVE;
      q.proc_id = ($urandom_range(1)) ? 16'($urandom_range(3)) : 16'($urandom);
      q.start_vaddr = {16'($urandom), 32'($urandom)};
      if ($urandom_range(1)) q.start_vaddr[47:20] = '0;
      q.page_count = 7'($urandom_range(1, max_cnt));
      q.home_block = ($urandom_range(2) == 0) ? 8'($urandom) : 8'(252 + $urandom_range(3));
    end
    if ($urandom_range(49) == 0) q.page_count = 7'($urandom_range(127));
    return q;
  endfunction

  task automatic run_random(int n, int max_cnt, int pct);
    idle_pct = pct;
    for (int i = 0; i < n; i++) pend_q.push_back(rand_req(max_cnt));
    wait_idle();
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    err_cnt = 0;
    idle_pct = 0;
    cfg_shift = PAGE_SHIFT_RST;
    cfg_ins_tries = MAX_INS_RST;
    cfg_rem_tries = MAX_REM_RST;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_owner[i] = '0;
      tbl_addr[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    pend_q.push_back(mk_req(KIND_INSERT, 16'h0000, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h0000, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h0001, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h0002, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h0000, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_INSERT, 16'hFFFF, 48'hFFFF_FFFF_F000, 7'd4, 8'd255));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h1234, 48'h0000_1000_0000, 7'd64, 8'd254));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h4321, 48'hAAAA_5555_A000, 7'd127, 8'd17));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h0007, 48'h0, 7'd0, 8'd3));
    pend_q.push_back(mk_req(KIND_REMOVE, 16'h0001, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_REMOVE, 16'h0001, 48'h0, 7'd1, 8'd0));
    pend_q.push_back(mk_req(KIND_REMOVE, 16'hFFFF, 48'hFFFF_FFFF_F000, 7'd4, 8'd255));
    pend_q.push_back(mk_req(KIND_REMOVE, 16'h1234, 48'h0000_1000_0000, 7'd64, 8'd254));
    pend_q.push_back(mk_req(KIND_REMOVE, 16'h0007, 48'h0, 7'd0, 8'd3));
    pend_q.push_back(mk_req(KIND_INSERT, 16'h5555, 48'h5555_5555_5123, 7'd3, 8'hAA));
    wait_idle();

    run_random(70, 8, 0);
    set_regs(32'd9, 32'd1, 32'd1);
    run_random(55, 8, 56);
    set_regs(32'd16, 32'd4096, 32'd4096);
    run_random(35, 2, 7);
    set_regs(32'd0, 32'd0, 32'd0);
    run_random(25, 8, 0);
    set_regs(32'hFFFF_FFFF, 32'd3, 32'd8);
    run_random(70, 16, 56);
    set_regs(32'd12, 32'd8191, 32'd3);
    run_random(20, 4, 7);
    set_regs(32'd13, 32'd40, 32'd300);
    run_random(110, 12, 0);
    wait_idle();
    repeat (100) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5s;
    $display("== FAIL ==");
    $finish;
  end

endmodule
